/* hw/rtl/wmib_pkg.sv */
// Shared widths, result record and output-stage control for the water mesh index builder.
// Used by wmib_out_stage, water_mesh_index_builder_core, wmib_index_checker and the testbench; depends on nothing else.

package wmib_pkg;

   // Default vertex grid edge length
   localparam int GRID_WIDTH_DEF = 32;

   // Field widths
   localparam int COORD_W = 5;
   localparam int ID_W    = 10;
   localparam int GID_W   = 11;

   // Stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 72;

   // One result record, without the last marker
   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic [ID_W-1:0]    vertex_id;
      logic [ID_W-1:0]    corner_a;
      logic [ID_W-1:0]    corner_b;
      logic [ID_W-1:0]    corner_c;
      logic [ID_W-1:0]    corner_d;
      logic [ID_W-1:0]    corner_e;
   } rslt_type;

   // Requests from the sequencer to the output stage
   typedef struct packed {
      logic push;
      logic finish;
   } os_ctl_type;

endpackage

/* hw/rtl/wmib_out_stage.sv */
// Output stage: holds back the latest result until it is known whether it is the final one,
// then hands it to a registered stream output. Depends on wmib_pkg.

module wmib_out_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  wmib_pkg::os_ctl_type             ctl,
   input  wmib_pkg::rslt_type               push_data,
   output logic                             ready,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata, low bit up: out_row[4:0], out_col[9:5], vertex_id[19:10], corner_a[29:20],
   // corner_b[39:30], corner_c[49:40], corner_d[59:50], corner_e[69:60], zero[71:70]
   output logic [wmib_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: kind
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import wmib_pkg::*;

   logic     pend_vld_ff, pend_vld_in;
   rslt_type pend_ff;
   logic     out_vld_ff, out_vld_in;
   rslt_type out_ff;
   logic     out_last_ff;
   logic     out_free;
   logic     move;
   logic     take;

   // Decide transfers between the holding slot and the output register
   always_comb begin
      out_free = !out_vld_ff || rsp_tready;
      ready    = !pend_vld_ff || out_free;
      take     = ctl.push && ready;
      move     = (ctl.push || ctl.finish) && ready && pend_vld_ff;

      pend_vld_in = pend_vld_ff;
      if (take) begin
         pend_vld_in = 1'b1;
      end else if (ctl.finish && ready) begin
         pend_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      if (move) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   // Hold control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (move) begin
         out_ff      <= pend_ff;
         out_last_ff <= ctl.finish;
      end
      if (take) begin
         pend_ff <= push_data;
      end
   end

   // Pack the stream output
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, out_ff.corner_e, out_ff.corner_d, out_ff.corner_c,
                        out_ff.corner_b, out_ff.corner_a, out_ff.vertex_id,
                        out_ff.out_col, out_ff.out_row};

   // A finish with a held result must present it as the final transfer
   a_finish_last : assert property (@(posedge clock) disable iff (reset)
      ctl.finish && ready && pend_vld_ff |=> rsp_tvalid && rsp_tlast)
      else $error("held result not released as final transfer");

   // Push and finish never arrive together
   a_ctl_excl : assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.finish))
      else $error("push and finish requested together");

   // A stalled transfer keeps its payload until it goes
   a_hold_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed before its transfer");

endmodule

/* hw/rtl/water_mesh_index_builder_core.sv */
// Top level of the water mesh index builder: step sequencer around the vertex-id and
// quad-done memories. Depends on wmib_pkg and wmib_out_stage.

// Usage:
// The req channel takes one item per transfer: req_tuser is the action (0 clear, 1 cell),
// req_tdata carries row, col and below_sea. A wet cell runs thirteen steps, one per cycle
// unless a step's result must wait for the output stage: nine neighbour vertices read from
// the vertex-id memory, then four quads read from the quad-done memory, with each read
// issued in the cycle before its check. New vertices and new quads leave on the rsp channel
// (rsp_tuser is the kind) with rsp_tlast on the final result of the item. After its last
// step a wet cell passes through a flush step before the next item is taken; a dry cell
// gives nothing. Each result is held back until the next result of the item or the end
// of the item so that the last marker can be set.
// A clear item, and reset, start a clearing pass over both memories that writes all
// GRID_WIDTH*GRID_WIDTH entries (1024 at the default width); req_tready stays low during it.
// When the receiver stalls, the sequencer holds at the step that wants to emit while the
// output register and one holding slot are full; a new item is taken while the last
// result of the previous one still waits in the output register.
module water_mesh_index_builder_core #(
   parameter int GRID_WIDTH = wmib_pkg::GRID_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_tdata, low bit up: row[4:0], col[9:5], below_sea[10], zero[15:11]
   input  logic [wmib_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: action
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata, low bit up: out_row[4:0], out_col[9:5], vertex_id[19:10], corner_a[29:20],
   // corner_b[39:30], corner_c[49:40], corner_d[59:50], corner_e[69:60], zero[71:70]
   output logic [wmib_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: kind
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import wmib_pkg::*;

   localparam int CELLS   = GRID_WIDTH * GRID_WIDTH;
   localparam int IDX_W   = $clog2(CELLS);
   localparam int STEP_W  = 4;
   localparam int NUM_VTX = 9;
   localparam logic [STEP_W-1:0] Q0_STEP   = STEP_W'(9);
   localparam logic [STEP_W-1:0] Q1_STEP   = STEP_W'(10);
   localparam logic [STEP_W-1:0] Q2_STEP   = STEP_W'(11);
   localparam logic [STEP_W-1:0] Q3_STEP   = STEP_W'(12);
   localparam logic [STEP_W-1:0] LAST_STEP = Q3_STEP;
   localparam logic [8:0] VTX_LIM  = 9'(GRID_WIDTH);
   localparam logic [8:0] QUAD_LIM = 9'(GRID_WIDTH - 1);
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(CELLS - 1);
   localparam logic ACT_CLEAR   = 1'b0;
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_QUAD   = 1'b1;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN, ST_FLUSH} state_type;

   typedef struct packed {
      logic               ok;
      logic [IDX_W-1:0]   idx;
      logic [COORD_W-1:0] r;
      logic [COORD_W-1:0] c;
   } loc_type;

   // Grid position of a step: neighbours in row-major order, then the four quads
   function automatic loc_type locate(input logic [COORD_W-1:0] row,
                                      input logic [COORD_W-1:0] col,
                                      input logic [STEP_W-1:0]  step);
      logic [1:0] dr;
      logic [1:0] dc;
      logic [8:0] rp;
      logic [8:0] cp;
      logic [8:0] lim;
      logic [8:0] r;
      logic [8:0] c;
      loc_type    l;
      unique case (step)
         4'd0:    begin dr = 2'd0; dc = 2'd0; end
         4'd1:    begin dr = 2'd0; dc = 2'd1; end
         4'd2:    begin dr = 2'd0; dc = 2'd2; end
         4'd3:    begin dr = 2'd1; dc = 2'd0; end
         4'd4:    begin dr = 2'd1; dc = 2'd1; end
         4'd5:    begin dr = 2'd1; dc = 2'd2; end
         4'd6:    begin dr = 2'd2; dc = 2'd0; end
         4'd7:    begin dr = 2'd2; dc = 2'd1; end
         4'd8:    begin dr = 2'd2; dc = 2'd2; end
         Q0_STEP: begin dr = 2'd0; dc = 2'd0; end
         Q1_STEP: begin dr = 2'd0; dc = 2'd1; end
         Q2_STEP: begin dr = 2'd1; dc = 2'd0; end
         Q3_STEP: begin dr = 2'd1; dc = 2'd1; end
         default: begin dr = 2'd0; dc = 2'd0; end
      endcase
      lim  = (step < STEP_W'(NUM_VTX)) ? VTX_LIM : QUAD_LIM;
      rp   = 9'(row) + 9'(dr);
      cp   = 9'(col) + 9'(dc);
      r    = rp - 9'd1;
      c    = cp - 9'd1;
      l.ok = (rp != 9'd0) && (cp != 9'd0) && (rp <= lim) && (cp <= lim);
      l.idx = l.ok ? IDX_W'(32'(r) * GRID_WIDTH + 32'(c)) : '0;
      l.r  = r[COORD_W-1:0];
      l.c  = c[COORD_W-1:0];
      return l;
   endfunction

   // Stored id is id+1; zero means unassigned
   function automatic logic [ID_W-1:0] corner_id(input logic [GID_W-1:0] g);
      logic [GID_W-1:0] v;
      v = g - GID_W'(1);
      return v[ID_W-1:0];
   endfunction

   // Memories and their registered read data
   logic [GID_W-1:0] vid_mem [CELLS];
   logic             quad_mem [CELLS];
   logic [GID_W-1:0] vid_rd_ff;
   logic             quad_rd_ff;

   // Control and payload registers
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [GID_W-1:0]   next_vtx_ff, next_vtx_in;
   logic [COORD_W-1:0] row_ff;
   logic [COORD_W-1:0] col_ff;
   logic [GID_W-1:0]   nb_ff [NUM_VTX];

   loc_type          chk_loc;
   loc_type          rd_loc;
   logic             accept;
   logic             start;
   logic             is_vtx;
   logic             emit;
   logic             advance;
   logic             rd_en;
   logic             vid_we;
   logic [IDX_W-1:0] vid_waddr;
   logic [GID_W-1:0] vid_wdata;
   logic             quad_we;
   logic [IDX_W-1:0] quad_waddr;
   logic             quad_wdata;
   logic [GID_W-1:0] nb_in;
   logic [GID_W-1:0] ga, gb, gc, gd;
   logic             os_ready;
   os_ctl_type       os_ctl;
   rslt_type         res;

   // Check the current step and issue the read for the next one
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      accept     = req_tvalid && req_tready;
      start      = accept && (req_tuser != ACT_CLEAR) && req_tdata[10];

      chk_loc = locate(row_ff, col_ff, step_ff);
      is_vtx  = step_ff < STEP_W'(NUM_VTX);
      emit    = (state_ff == ST_RUN) && chk_loc.ok &&
                (is_vtx ? (vid_rd_ff == '0) : !quad_rd_ff);
      advance = (state_ff == ST_RUN) && (!emit || os_ready);

      if (state_ff == ST_IDLE) begin
         rd_loc = locate(req_tdata[4:0], req_tdata[9:5], '0);
      end else begin
         rd_loc = locate(row_ff, col_ff, step_ff + STEP_W'(1));
      end
      rd_en = start || (advance && (step_ff != LAST_STEP));

      nb_in = emit ? (next_vtx_ff + GID_W'(1)) : vid_rd_ff;
   end

   // Select the memory write: clearing pass, new vertex, or quad done
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         vid_we     = 1'b1;
         vid_waddr  = clr_addr_ff;
         vid_wdata  = '0;
         quad_we    = 1'b1;
         quad_waddr = clr_addr_ff;
         quad_wdata = 1'b0;
      end else begin
         vid_we     = advance && emit && is_vtx;
         vid_waddr  = chk_loc.idx;
         vid_wdata  = next_vtx_ff + GID_W'(1);
         quad_we    = advance && emit && !is_vtx;
         quad_waddr = chk_loc.idx;
         quad_wdata = 1'b1;
      end
   end

   // Pick the quad corners from the neighbourhood ids
   always_comb begin
      unique case (step_ff)
         Q0_STEP: begin ga = nb_ff[0]; gb = nb_ff[3]; gc = nb_ff[4]; gd = nb_ff[1]; end
         Q1_STEP: begin ga = nb_ff[1]; gb = nb_ff[4]; gc = nb_ff[5]; gd = nb_ff[2]; end
         Q2_STEP: begin ga = nb_ff[3]; gb = nb_ff[6]; gc = nb_ff[7]; gd = nb_ff[4]; end
         Q3_STEP: begin ga = nb_ff[4]; gb = nb_ff[7]; gc = nb_ff[8]; gd = nb_ff[5]; end
         default: begin ga = nb_ff[0]; gb = nb_ff[0]; gc = nb_ff[0]; gd = nb_ff[0]; end
      endcase
   end

   // Build the result record
   always_comb begin
      res.out_row = chk_loc.r;
      res.out_col = chk_loc.c;
      if (is_vtx) begin
         res.kind      = KIND_VERTEX;
         res.vertex_id = next_vtx_ff[ID_W-1:0];
         res.corner_a  = '0;
         res.corner_b  = '0;
         res.corner_c  = '0;
         res.corner_d  = '0;
         res.corner_e  = '0;
      end else begin
         res.kind      = KIND_QUAD;
         res.vertex_id = '0;
         res.corner_a  = corner_id(ga);
         res.corner_b  = corner_id(gb);
         res.corner_c  = corner_id(gc);
         res.corner_d  = corner_id(gd);
         res.corner_e  = corner_id(ga);
      end
      os_ctl.push   = emit;
      os_ctl.finish = (state_ff == ST_FLUSH);
   end

   // Next state of the sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      step_in     = step_ff;
      next_vtx_in = next_vtx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               clr_addr_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_tuser == ACT_CLEAR)) begin
               state_in    = ST_CLEAR;
               clr_addr_in = '0;
               next_vtx_in = '0;
            end else if (start) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (advance) begin
               if (emit && is_vtx) begin
                  next_vtx_in = next_vtx_ff + GID_W'(1);
               end
               if (step_ff == LAST_STEP) begin
                  state_in = ST_FLUSH;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (os_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         step_ff     <= '0;
         next_vtx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         step_ff     <= step_in;
         next_vtx_ff <= next_vtx_in;
      end
   end

   // Latch the cell and record neighbourhood ids
   always_ff @(posedge clock) begin
      if (start) begin
         row_ff <= req_tdata[4:0];
         col_ff <= req_tdata[9:5];
      end
      if (advance && is_vtx) begin
         nb_ff[step_ff] <= nb_in;
      end
   end

   // Vertex-id memory
   always_ff @(posedge clock) begin
      if (vid_we) begin
         vid_mem[vid_waddr] <= vid_wdata;
      end
      if (rd_en) begin
         vid_rd_ff <= vid_mem[rd_loc.idx];
      end
   end

   // Quad-done memory
   always_ff @(posedge clock) begin
      if (quad_we) begin
         quad_mem[quad_waddr] <= quad_wdata;
      end
      if (rd_en) begin
         quad_rd_ff <= quad_mem[rd_loc.idx];
      end
   end

   wmib_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .ctl        (os_ctl),
      .push_data  (res),
      .ready      (os_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A read issued one step ahead never hits the entry being written
   a_no_rw_clash : assert property (@(posedge clock) disable iff (reset)
      vid_we && rd_en && rd_loc.ok |-> vid_waddr != rd_loc.idx)
      else $error("vertex memory read and write hit the same entry");

   // The final step hands over to the flush
   a_last_flush : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && step_ff == LAST_STEP && advance |=> state_ff == ST_FLUSH)
      else $error("final step did not lead to flush");

   // Each new vertex takes exactly the next id
   a_vtx_count : assert property (@(posedge clock) disable iff (reset)
      vid_we && state_ff == ST_RUN |=> next_vtx_ff == $past(next_vtx_ff) + GID_W'(1))
      else $error("vertex counter out of step with vertex writes");

endmodule

/* tb/sv/wmib_tb_pkg.sv */
// Action and result-kind codes shared by the water mesh index builder testbench files.
// Used by wmib_index_checker and tb_water_mesh_index_builder_core; depends on nothing else.

package wmib_tb_pkg;

   // What a req transfer asks for (travels on req_tuser)
   typedef enum logic {
      ACT_CLEAR = 1'b0,
      ACT_CELL  = 1'b1
   } cell_action_type;

   // What an rsp transfer carries (travels on rsp_tuser)
   typedef enum logic {
      KIND_VERTEX = 1'b0,
      KIND_QUAD   = 1'b1
   } result_kind_type;

endpackage

/* tb/sv/wmib_index_checker.sv */
// Watches both streams of the water mesh index builder, predicts the vertex and quad results
// of every accepted cell and compares them in order. Depends on wmib_pkg and wmib_tb_pkg.

module wmib_index_checker #(
   parameter int GRID_WIDTH = wmib_pkg::GRID_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // req_tdata, low bit up: row[4:0], col[9:5], below_sea[10], zero[15:11]
   input  logic [wmib_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: action
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata, low bit up: out_row[4:0], out_col[9:5], vertex_id[19:10], corner_a[29:20],
   // corner_b[39:30], corner_c[49:40], corner_d[59:50], corner_e[69:60], zero[71:70]
   input  logic [wmib_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: kind
   input  logic                             rsp_tuser,
   input  logic                             rsp_tlast,
   output int                               fail_count,
   output int                               pending_count
);

   import wmib_pkg::*;
   import wmib_tb_pkg::*;

   localparam int CELLS = GRID_WIDTH * GRID_WIDTH;

   typedef struct packed {
      rslt_type body;
      logic     last;
   } mesh_result_type;

   // Predicted patch state: id+1 per vertex (0 = unassigned) and emitted-quad flags
   logic [GID_W-1:0] vertex_slot [CELLS];
   logic             quad_done   [CELLS];
   logic [GID_W-1:0] next_id;

   mesh_result_type  awaited_results [$];
   int               fails;

   task automatic clear_patch();
      foreach (vertex_slot[i]) begin
         vertex_slot[i] = '0;
         quad_done[i]   = 1'b0;
      end
      next_id = '0;
   endtask

   function automatic logic [ID_W-1:0] id_at(int r, int c);
      logic [GID_W-1:0] g;
      g = vertex_slot[r * GRID_WIDTH + c] - 1'b1;
      return g[ID_W-1:0];
   endfunction

   // Number new neighbours in row-major order, then emit the not yet emitted in-grid quads of the four around the cell
   task automatic build_cell_indices(int row, int col);
      int              r;
      int              c;
      int              first;
      mesh_result_type item;
      first = awaited_results.size();
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            r = row + dr;
            c = col + dc;
            if (r < 0 || c < 0 || r >= GRID_WIDTH || c >= GRID_WIDTH) continue;
            if (vertex_slot[r * GRID_WIDTH + c] != '0) continue;
            vertex_slot[r * GRID_WIDTH + c] = next_id + 1'b1;
            item = '0;
            item.body.kind      = KIND_VERTEX;
            item.body.out_row   = r[COORD_W-1:0];
            item.body.out_col   = c[COORD_W-1:0];
            item.body.vertex_id = next_id[ID_W-1:0];
            awaited_results.push_back(item);
            next_id = next_id + 1'b1;
         end
      end
      for (int q = 0; q < 4; q++) begin
         r = row - 1 + (q >> 1);
         c = col - 1 + (q & 1);
         if (r < 0 || c < 0 || r >= GRID_WIDTH - 1 || c >= GRID_WIDTH - 1) continue;
         if (quad_done[r * GRID_WIDTH + c]) continue;
         quad_done[r * GRID_WIDTH + c] = 1'b1;
         item = '0;
         item.body.kind     = KIND_QUAD;
         item.body.out_row  = r[COORD_W-1:0];
         item.body.out_col  = c[COORD_W-1:0];
         item.body.corner_a = id_at(r, c);
         item.body.corner_b = id_at(r + 1, c);
         item.body.corner_c = id_at(r + 1, c + 1);
         item.body.corner_d = id_at(r, c + 1);
         item.body.corner_e = item.body.corner_a;
         awaited_results.push_back(item);
      end
      if (awaited_results.size() > first)
         awaited_results[awaited_results.size() - 1].last = 1'b1;
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   // Compare each result transfer with the oldest prediction, then predict new cells
   always @(posedge clock) begin
      mesh_result_type want;
      if (reset) begin
         clear_patch();
         awaited_results.delete();
         fails = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $error("result transfer with nothing awaited: tdata %h", rsp_tdata);
               fails++;
            end else begin
               want = awaited_results.pop_front();
               check_field("kind",      want.body.kind,      rsp_tuser);
               check_field("out_row",   want.body.out_row,   rsp_tdata[4:0]);
               check_field("out_col",   want.body.out_col,   rsp_tdata[9:5]);
               check_field("vertex_id", want.body.vertex_id, rsp_tdata[19:10]);
               check_field("corner_a",  want.body.corner_a,  rsp_tdata[29:20]);
               check_field("corner_b",  want.body.corner_b,  rsp_tdata[39:30]);
               check_field("corner_c",  want.body.corner_c,  rsp_tdata[49:40]);
               check_field("corner_d",  want.body.corner_d,  rsp_tdata[59:50]);
               check_field("corner_e",  want.body.corner_e,  rsp_tdata[69:60]);
               check_field("last",      want.last,           rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACT_CLEAR)
               clear_patch();
            else if (req_tdata[10])
               build_cell_indices(int'(req_tdata[4:0]), int'(req_tdata[9:5]));
         end
      end
      fail_count    <= fails;
      pending_count <= awaited_results.size();
   end

endmodule

/* tb/sv/tb_water_mesh_index_builder_core.sv */
// Stimulus and verdict for the water mesh index builder: drives cells and clears in bursts,
// stalls the result stream and runs a stall watchdog. Depends on wmib_pkg, wmib_tb_pkg,
// wmib_index_checker and water_mesh_index_builder_core.

module tb_water_mesh_index_builder_core;

   import wmib_pkg::*;
   import wmib_tb_pkg::*;

   localparam int ITEM_TARGET   = 380;
   localparam int STALL_LIMIT   = 6000;
   localparam int SETTLE_CYCLES = 40;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   int                    fail_count;
   int                    pending_count;
   int                    idle_cycles = 0;

   water_mesh_index_builder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   wmib_index_checker u_index_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #2 clock = ~clock;

   // Receiver: switch between free flow, random and long stalls every so often
   int ready_mode = 0;
   int mode_left  = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left = mode_left - 1;
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: begin
            if (stall_left > 0) begin
               stall_left = stall_left - 1;
               rsp_tready <= 1'b0;
            end else begin
               if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 15);
               rsp_tready <= 1'b1;
            end
         end
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("tb_water_mesh_index_builder_core NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one item from a falling edge and hold it until its transfer
   task automatic send_item(cell_action_type act, logic [4:0] row, logic [4:0] col,
                            logic wet);
      req_tuser  = act;
      req_tdata  = {5'b0, wet, col, row};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic idle_sender(int cycles);
      req_tvalid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Hold the sender until every predicted result has gone out
   task automatic drain_results();
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      int         sent;
      int         burst;
      int         choice;
      logic [4:0] walk_row;
      logic [4:0] walk_col;
      logic [4:0] pick_row;
      logic [4:0] pick_col;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_CLEAR;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Corners, edges, a repeated cell and dry cells
      send_item(ACT_CELL, 5'd0, 5'd0, 1'b1);
      send_item(ACT_CELL, 5'd0, 5'd0, 1'b1);
      send_item(ACT_CELL, 5'd0, 5'd1, 1'b1);
      send_item(ACT_CELL, 5'd31, 5'd31, 1'b1);
      send_item(ACT_CELL, 5'd31, 5'd0, 1'b1);
      send_item(ACT_CELL, 5'd0, 5'd31, 1'b1);
      send_item(ACT_CELL, 5'd30, 5'd30, 1'b1);
      send_item(ACT_CELL, 5'd10, 5'd10, 1'b0);
      send_item(ACT_CELL, 5'd31, 5'd31, 1'b0);
      idle_sender(3);
      // Clear with every ignored field set, then a full 3x3 neighbourhood
      send_item(ACT_CLEAR, 5'd31, 5'd31, 1'b1);
      send_item(ACT_CELL, 5'd1, 5'd1, 1'b1);
      send_item(ACT_CELL, 5'd1, 5'd2, 1'b1);
      send_item(ACT_CELL, 5'd2, 5'd1, 1'b1);
      send_item(ACT_CELL, 5'd21, 5'd10, 1'b1);
      send_item(ACT_CELL, 5'd10, 5'd21, 1'b1);
      send_item(ACT_CELL, 5'd16, 5'd15, 1'b1);
      send_item(ACT_CELL, 5'd16, 5'd16, 1'b1);
      send_item(ACT_CLEAR, 5'd0, 5'd0, 1'b0);
      send_item(ACT_CELL, 5'd31, 5'd30, 1'b1);
      drain_results();

      // Random bursts: mostly walks over nearby water cells, some jumps, edges, dry and clears
      walk_row = 5'd16;
      walk_col = 5'd16;
      sent     = 0;
      while (sent < ITEM_TARGET) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst; i++) begin
            choice = $urandom_range(0, 99);
            if (choice < 2) begin
               send_item(ACT_CLEAR, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                         1'($urandom_range(0, 1)));
            end else if (choice < 12) begin
               send_item(ACT_CELL, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                         1'b0);
            end else if (choice < 65) begin
               walk_row = walk_row + 5'($urandom_range(0, 2)) - 5'd1;
               walk_col = walk_col + 5'($urandom_range(0, 2)) - 5'd1;
               send_item(ACT_CELL, walk_row, walk_col, 1'b1);
            end else if (choice < 75) begin
               pick_row = 5'($urandom_range(0, 31));
               pick_col = 5'($urandom_range(0, 31));
               case ($urandom_range(0, 3))
                  0: pick_row = 5'd0;
                  1: pick_row = 5'd31;
                  2: pick_col = 5'd0;
                  default: pick_col = 5'd31;
               endcase
               send_item(ACT_CELL, pick_row, pick_col, 1'b1);
            end else begin
               walk_row = 5'($urandom_range(0, 31));
               walk_col = 5'($urandom_range(0, 31));
               send_item(ACT_CELL, walk_row, walk_col, 1'b1);
            end
            sent++;
         end
         // Gap between bursts: sometimes none, sometimes a short idle, sometimes a full drain
         if ($urandom_range(0, 15) == 0)
            drain_results();
         else if ($urandom_range(0, 3) != 0)
            idle_sender($urandom_range(1, 10));
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("tb_water_mesh_index_builder_core OK");
      else
         $display("tb_water_mesh_index_builder_core NOT OK");
      $finish;
   end

endmodule

/* water_mesh_index_builder_core.f */
hw/rtl/wmib_pkg.sv
hw/rtl/wmib_out_stage.sv
hw/rtl/water_mesh_index_builder_core.sv
tb/sv/wmib_tb_pkg.sv
tb/sv/wmib_index_checker.sv
tb/sv/tb_water_mesh_index_builder_core.sv
